FILE: hdl/irn_pkg.sv
// Shared types and constants for the rotating frame store.
`default_nettype none
package irn_pkg;

  localparam int unsigned PIX_W   = 8;   // one color channel
  localparam int unsigned COORD_W = 8;   // request/store row and column
  localparam int unsigned CNT_W   = 9;   // row_count / col_count registers
  localparam int unsigned COEF_W  = 16;  // cos_coef / sin_coef registers
  localparam int unsigned OFS_W   = 11;  // 2*coord - count, signed
  localparam int unsigned PROD_W  = OFS_W + COEF_W;
  localparam int unsigned CFG_AW  = 2;

  // Register map of the configuration port
  typedef enum logic [CFG_AW-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1,
    CFG_COS_COEF  = 2'd2,
    CFG_SIN_COEF  = 2'd3
  } cfg_idx_e;

  // Kind of an input beat, carried on tuser
  typedef enum logic {
    CMD_STORE   = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [PIX_W-1:0] chan2;
    logic [PIX_W-1:0] chan1;
    logic [PIX_W-1:0] chan0;
  } pixel_t;

  localparam pixel_t FILL_PIXEL = '{chan2: 8'd0, chan1: 8'd0, chan0: 8'd128};

  localparam logic [CNT_W-1:0]  ROW_COUNT_RST = 9'd256;
  localparam logic [CNT_W-1:0]  COL_COUNT_RST = 9'd256;
  localparam logic [COEF_W-1:0] COS_COEF_RST  = 16'sd16384;
  localparam logic [COEF_W-1:0] SIN_COEF_RST  = 16'sd0;

endpackage
`default_nettype wire

FILE: hdl/image_rotate_nearest_core.sv
// Rotating frame store: pixel store, inverse-rotation address path, pixel readback.
//
// Input stream (s_axis): tuser selects the beat kind. A store beat writes the
// pixel in tdata at (row, col) and produces nothing downstream. A request beat
// names an output position; the block rotates it back about the frame center
// using cos_coef/sin_coef and returns the stored pixel at the source position,
// or the fill pixel (128,0,0) with tuser low when the source is off the frame.
// Output stream (m_axis): one beat per request, in request order.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, written while the block is idle.
//
// Pipeline: offset multiply, sum, frame-store read into the output register. A
// request passes the product, sum and output registers to m_axis. One beat per cycle
// is sustained while m_axis is ready; the single frame-store port serves either
// the write of a store beat or the read of a request beat in each cycle, in stream order.
// When m_axis stalls, the whole pipeline holds and s_axis_tready drops.
// Reset clears the pipeline valids and loads the default registers
// (256 x 256 frame, no rotation); the frame store itself is not cleared.
`default_nettype none
module image_rotate_nearest_core
  import irn_pkg::*;
#(
  parameter int unsigned MAX_ROWS       = 256,
  parameter int unsigned MAX_COLS       = 256,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_AW-1:0]   cfg_idx_i,
  input  wire logic [COEF_W-1:0]   cfg_data_i,
  // input beats
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [39:0]         s_axis_tdata,  // row, col, chan0_in, chan1_in, chan2_in
  input  wire logic                s_axis_tuser,  // cmd
  // result beats
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [23:0]         m_axis_tdata,  // chan0_out, chan1_out, chan2_out
  output      logic                m_axis_tuser   // inside_res
);

  localparam int unsigned ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned SHIFT  = COEF_FRAC_BITS + 1;
  // room for count << frac plus two products, and the coordinate bits above SHIFT
  localparam int unsigned SUM_W  = ((COEF_FRAC_BITS + 14) > 28) ? (COEF_FRAC_BITS + 14) : 28;
  localparam logic signed [SUM_W-1:0] LOW_LIMIT = -(SUM_W'(1) << SHIFT);

  // configuration registers
  logic [CNT_W-1:0]         row_count_q, col_count_q;
  logic signed [COEF_W-1:0] cos_q, sin_q;
  logic [CNT_W-1:0]         rows_eff, cols_eff;

  // input unpacking
  logic [COORD_W-1:0] in_row, in_col;
  pixel_t             in_pix;
  logic               in_wr_ok;
  logic signed [OFS_W-1:0] dr2, dc2;

  logic pipe_en;

  // stage 1: products
  logic                     v1_q;
  cmd_e                     cmd1_q;
  logic                     wr_ok1_q;
  logic [ROW_AW-1:0]        row1_q;
  logic [COL_AW-1:0]        col1_q;
  pixel_t                   pix1_q;
  logic signed [PROD_W-1:0] p_rc_q, p_cs_q, p_rs_q, p_cc_q;

  // stage 2: sums
  logic                     v2_q;
  cmd_e                     cmd2_q;
  logic                     wr_ok2_q;
  logic [ROW_AW-1:0]        row2_q;
  logic [COL_AW-1:0]        col2_q;
  pixel_t                   pix2_q;
  logic signed [SUM_W-1:0]  xs_q, ys_q;
  logic signed [SUM_W-1:0]  xs_d, ys_d;

  // stage 3: frame store access
  logic signed [SUM_W-1:0]  x_hi, y_hi;
  logic                     x_in, y_in, inside_d;
  logic [ROW_AW-1:0]        src_row;
  logic [COL_AW-1:0]        src_col;
  logic                     mem_we;
  logic                     v3_q;
  logic                     inside3_q;
  pixel_t                   rd_q;

  pixel_t mem [MAX_ROWS][MAX_COLS];

  // ---------------------------------------------------------------------------
  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
      cos_q       <= COS_COEF_RST;
      sin_q       <= SIN_COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_COUNT: row_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_COL_COUNT: col_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_COS_COEF:  cos_q       <= cfg_data_i;
        CFG_SIN_COEF:  sin_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counts above the store saturate
  assign rows_eff = (32'(row_count_q) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : row_count_q;
  assign cols_eff = (32'(col_count_q) > MAX_COLS) ? CNT_W'(MAX_COLS) : col_count_q;

  // ---------------------------------------------------------------------------
  // stage 0 -> 1
  assign pipe_en       = !v3_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  assign in_row   = s_axis_tdata[7:0];
  assign in_col   = s_axis_tdata[15:8];
  assign in_pix   = pixel_t'({s_axis_tdata[39:32], s_axis_tdata[31:24], s_axis_tdata[23:16]});
  assign in_wr_ok = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);

  // offsets with one fractional bit
  assign dr2 = $signed({2'b00, in_row, 1'b0}) - $signed({2'b00, rows_eff});
  assign dc2 = $signed({2'b00, in_col, 1'b0}) - $signed({2'b00, cols_eff});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      cmd1_q   <= cmd_e'(s_axis_tuser);
      wr_ok1_q <= in_wr_ok;
      row1_q   <= ROW_AW'(in_row);
      col1_q   <= COL_AW'(in_col);
      pix1_q   <= in_pix;
      p_rc_q   <= dr2 * cos_q;
      p_cs_q   <= dc2 * sin_q;
      p_rs_q   <= dr2 * sin_q;
      p_cc_q   <= dc2 * cos_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 -> 2
  assign xs_d = (SUM_W'(rows_eff) << COEF_FRAC_BITS) + SUM_W'(p_rc_q) - SUM_W'(p_cs_q);
  assign ys_d = (SUM_W'(cols_eff) << COEF_FRAC_BITS) + SUM_W'(p_rs_q) + SUM_W'(p_cc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (pipe_en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      cmd2_q   <= cmd1_q;
      wr_ok2_q <= wr_ok1_q;
      row2_q   <= row1_q;
      col2_q   <= col1_q;
      pix2_q   <= pix1_q;
      xs_q     <= xs_d;
      ys_q     <= ys_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2 -> 3: truncation toward zero folds (-1, 0) onto zero
  assign x_hi = SUM_W'(rows_eff) << SHIFT;
  assign y_hi = SUM_W'(cols_eff) << SHIFT;
  assign x_in = (xs_q > LOW_LIMIT) && (xs_q < x_hi);
  assign y_in = (ys_q > LOW_LIMIT) && (ys_q < y_hi);
  assign inside_d = x_in && y_in;

  assign src_row = xs_q[SUM_W-1] ? '0 : xs_q[SHIFT +: ROW_AW];
  assign src_col = ys_q[SUM_W-1] ? '0 : ys_q[SHIFT +: COL_AW];

  assign mem_we = pipe_en && v2_q && (cmd2_q == CMD_STORE) && wr_ok2_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[row2_q][col2_q] <= pix2_q;
    end
    if (pipe_en) begin
      rd_q      <= mem[src_row][src_col];
      inside3_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (pipe_en) begin
      v3_q <= v2_q && (cmd2_q == CMD_REQUEST);
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = inside3_q ? rd_q : FILL_PIXEL;
  assign m_axis_tuser  = inside3_q;

  // ---------------------------------------------------------------------------
  // checks
  a_req_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_en && v2_q && (cmd2_q == CMD_REQUEST) |=> m_axis_tvalid)
    else $error("request beat did not reach the output");

  a_store_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_en && !(v2_q && (cmd2_q == CMD_REQUEST)) |=> !m_axis_tvalid)
    else $error("output beat without a request");

  // off-frame beats carry the fill pixel, so the raw read data is not compared
  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled readback data changed");

endmodule
`default_nettype wire
